// ----- sv/stl_pkg.sv -----
// shared types, character codes and helper functions for the source token lexer
`timescale 1ns / 1ps

package stl_pkg;

	// default width of the position, start and length counters
	localparam int OFFSET_WIDTH = 16;

	// lexer modes
	typedef enum logic [3:0] {
		MODE_IDLE       = 4'd0,
		MODE_IDENT      = 4'd1,
		MODE_NUMBER     = 4'd2,
		MODE_STRING     = 4'd3,
		MODE_CHAR       = 4'd4,
		MODE_OPER       = 4'd5,
		MODE_OPER_SLASH = 4'd6,
		MODE_LINE       = 4'd7,
		MODE_BLOCK      = 4'd8
	} mode_t;

	// token kinds as they leave the block
	typedef enum logic [2:0] {
		KIND_IDENT  = 3'd0,
		KIND_IF     = 3'd1,
		KIND_ELSE   = 3'd2,
		KIND_NUMBER = 3'd3,
		KIND_STRING = 3'd4,
		KIND_CHAR   = 3'd5,
		KIND_OPER   = 3'd6,
		KIND_ERROR  = 3'd7
	} kind_t;

	// partial keyword match inside an identifier
	typedef enum logic [2:0] {
		KW_NONE = 3'd0,
		KW_I    = 3'd1,
		KW_IF   = 3'd2,
		KW_E    = 3'd3,
		KW_EL   = 3'd4,
		KW_ELS  = 3'd5,
		KW_ELSE = 3'd6
	} kw_t;

	// one token record
	typedef struct packed {
		kind_t       token_kind;
		logic [15:0] start_offset;
		logic [15:0] token_length;
		logic        last_of_item;
		logic        final_token;
	} tok_rec_t;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] CH_UPZ   = 8'h5A;
	localparam logic [7:0] CH_LOA   = 8'h61;
	localparam logic [7:0] CH_LOE   = 8'h65;
	localparam logic [7:0] CH_LOF   = 8'h66;
	localparam logic [7:0] CH_LOI   = 8'h69;
	localparam logic [7:0] CH_LOL   = 8'h6C;
	localparam logic [7:0] CH_LOS   = 8'h73;
	localparam logic [7:0] CH_LOZ   = 8'h7A;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_UPA) && (c <= CH_UPZ)) || ((c >= CH_LOA) && (c <= CH_LOZ));
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH)
			|| (c == CH_PCT) || (c == CH_EQ);
	endfunction

	// advance the keyword tracker by one identifier byte
	function automatic kw_t kw_next(input kw_t k, input logic [7:0] c);
		kw_t r;
		r = KW_NONE;
		if (k == KW_I && c == CH_LOF) r = KW_IF;
		if (k == KW_E && c == CH_LOL) r = KW_EL;
		if (k == KW_EL && c == CH_LOS) r = KW_ELS;
		if (k == KW_ELS && c == CH_LOE) r = KW_ELSE;
		return r;
	endfunction

	// kind of a closed identifier
	function automatic kind_t ident_kind(input kw_t k);
		kind_t r;
		r = KIND_IDENT;
		if (k == KW_IF) r = KIND_IF;
		if (k == KW_ELSE) r = KIND_ELSE;
		return r;
	endfunction

endpackage

// ----- sv/stl_if.sv -----
// valid/ready channels for source bytes and token records
`timescale 1ns / 1ps

interface stl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_input;

	modport source (output valid, output char_in, output end_of_input, input ready);
	modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface stl_tok_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic        last_of_item;
	logic        final_token;

	modport source (output valid, output token_kind, output start_offset,
		output token_length, output last_of_item, output final_token, input ready);
	modport sink (input valid, input token_kind, input start_offset,
		input token_length, input last_of_item, input final_token, output ready);
endinterface

// ----- sv/source_token_lexer.sv -----
// source token lexer: byte stream in, token records out
//
//  channel  dir  payload
//  text     in   char_in[7:0], end_of_input
//  tokens   out  token_kind[2:0], start_offset[15:0], token_length[15:0],
//                last_of_item, final_token
//
// one byte is accepted per cycle while text.ready is high; the mode update is
// a single pass of logic between the byte register and a four-entry token buffer
// a token passes from the byte register into the token buffer, whose head drives the output
// a byte may close one token and, at end of input, emit a second one, so each
// token needs its own output beat; the buffer must hold two free slots for
// a byte to move on, and text.ready drops while it cannot
// reset clears the mode, counters and buffer at once; no clearing pass
`timescale 1ns / 1ps

module source_token_lexer #(
	parameter int OFFSET_WIDTH = stl_pkg::OFFSET_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	stl_byte_if.sink     text,
	stl_tok_if.source    tokens
);

	localparam int OW = OFFSET_WIDTH;
	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [OW-1:0] LIM16 = OW'(17'h0FFFF);

	// byte register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	// lexer state
	stl_pkg::mode_t mode_q, mode_m;
	stl_pkg::kw_t   kw_q, kw_m;
	logic [OW-1:0]  pos_q, tstart_q, tstart_m, len_q, len_m;
	logic           pstar_q, pstar_m;

	// token buffer
	stl_pkg::tok_rec_t fifo_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	logic room, adv, pop;
	logic emit_a, emit_b;
	stl_pkg::tok_rec_t rec_a, rec_b, first_rec;
	logic [1:0] push_cnt;

	function automatic logic [OW-1:0] sat_inc(input logic [OW-1:0] v);
		return (v == {OW{1'b1}}) ? v : v + OW'(1);
	endfunction

	function automatic logic [15:0] clamp16(input logic [OW-1:0] v);
		return (v > LIM16) ? 16'hFFFF : 16'(v);
	endfunction

	function automatic stl_pkg::tok_rec_t mk_rec(input stl_pkg::kind_t k,
			input logic [OW-1:0] s, input logic [OW-1:0] l);
		stl_pkg::tok_rec_t r;
		r.token_kind   = k;
		r.start_offset = clamp16(s);
		r.token_length = clamp16(l);
		r.last_of_item = 1'b0;
		r.final_token  = 1'b0;
		return r;
	endfunction

	// handshake
	assign room = cnt_q <= CNT_W'(DEPTH - 2);
	assign adv = valid_s1 && room;
	assign text.ready = !valid_s1 || room;
	assign pop = tokens.valid && tokens.ready;

	// byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			char_s1 <= text.char_in;
			eoi_s1  <= text.end_of_input;
		end
	end

	// next state for one byte, before the end-of-input reset
	always_comb begin
		logic restart;
		logic [7:0] c;
		c        = char_s1;
		restart  = 1'b0;
		mode_m   = mode_q;
		kw_m     = kw_q;
		tstart_m = tstart_q;
		len_m    = len_q;
		pstar_m  = pstar_q;
		unique case (mode_q)
			stl_pkg::MODE_STRING: begin
				if (c == stl_pkg::CH_DQUOT) mode_m = stl_pkg::MODE_IDLE;
				else len_m = sat_inc(len_q);
			end
			stl_pkg::MODE_CHAR: begin
				if (c == stl_pkg::CH_SQUOT) mode_m = stl_pkg::MODE_IDLE;
				else len_m = sat_inc(len_q);
			end
			stl_pkg::MODE_LINE: begin
				if (c == stl_pkg::CH_LF) mode_m = stl_pkg::MODE_IDLE;
			end
			stl_pkg::MODE_BLOCK: begin
				if (pstar_q && c == stl_pkg::CH_SLASH) begin
					mode_m  = stl_pkg::MODE_IDLE;
					pstar_m = 1'b0;
				end else begin
					pstar_m = (c == stl_pkg::CH_STAR);
					len_m   = sat_inc(len_q);
				end
			end
			stl_pkg::MODE_IDENT: begin
				if (stl_pkg::is_letter(c) || stl_pkg::is_digit(c)) begin
					len_m = sat_inc(len_q);
					kw_m  = stl_pkg::kw_next(kw_q, c);
				end else begin
					restart = 1'b1;
				end
			end
			stl_pkg::MODE_NUMBER: begin
				if (stl_pkg::is_digit(c)) len_m = sat_inc(len_q);
				else restart = 1'b1;
			end
			stl_pkg::MODE_OPER_SLASH, stl_pkg::MODE_OPER: begin
				if (mode_q == stl_pkg::MODE_OPER_SLASH
						&& (c == stl_pkg::CH_SLASH || c == stl_pkg::CH_STAR)) begin
					// comment opens; the slash belongs to it
					mode_m   = (c == stl_pkg::CH_SLASH) ? stl_pkg::MODE_LINE
						: stl_pkg::MODE_BLOCK;
					tstart_m = (pos_q != '0) ? pos_q - OW'(1) : '0;
					len_m    = '0;
					pstar_m  = 1'b0;
				end else if (stl_pkg::is_op(c)) begin
					len_m  = sat_inc(len_q);
					mode_m = (c == stl_pkg::CH_SLASH) ? stl_pkg::MODE_OPER_SLASH
						: stl_pkg::MODE_OPER;
				end else begin
					restart = 1'b1;
				end
			end
			default: restart = 1'b1;
		endcase

		// the closing byte starts whatever follows
		if (restart) begin
			len_m = '0;
			if (stl_pkg::is_op(c)) begin
				mode_m   = (c == stl_pkg::CH_SLASH) ? stl_pkg::MODE_OPER_SLASH
					: stl_pkg::MODE_OPER;
				tstart_m = pos_q;
				len_m    = OW'(1);
			end else if (stl_pkg::is_digit(c)) begin
				mode_m   = stl_pkg::MODE_NUMBER;
				tstart_m = pos_q;
				len_m    = OW'(1);
			end else if (stl_pkg::is_letter(c)) begin
				mode_m   = stl_pkg::MODE_IDENT;
				tstart_m = pos_q;
				len_m    = OW'(1);
				kw_m     = (c == stl_pkg::CH_LOI) ? stl_pkg::KW_I
					: ((c == stl_pkg::CH_LOE) ? stl_pkg::KW_E : stl_pkg::KW_NONE);
			end else if (c == stl_pkg::CH_DQUOT || c == stl_pkg::CH_SQUOT) begin
				mode_m   = (c == stl_pkg::CH_DQUOT) ? stl_pkg::MODE_STRING
					: stl_pkg::MODE_CHAR;
				tstart_m = sat_inc(pos_q);
			end else begin
				mode_m = stl_pkg::MODE_IDLE;
			end
		end
	end

	// token records produced by one byte
	always_comb begin
		logic [7:0] c;
		c      = char_s1;
		emit_a = 1'b0;
		emit_b = 1'b0;
		rec_a  = mk_rec(stl_pkg::KIND_OPER, tstart_q, len_q);
		rec_b  = mk_rec(stl_pkg::KIND_ERROR, tstart_m, len_m);
		// token closed by this byte
		unique case (mode_q)
			stl_pkg::MODE_STRING: begin
				emit_a = (c == stl_pkg::CH_DQUOT);
				rec_a  = mk_rec(stl_pkg::KIND_STRING, tstart_q, len_q);
			end
			stl_pkg::MODE_CHAR: begin
				emit_a = (c == stl_pkg::CH_SQUOT);
				rec_a  = mk_rec(stl_pkg::KIND_CHAR, tstart_q, len_q);
			end
			stl_pkg::MODE_IDENT: begin
				emit_a = !(stl_pkg::is_letter(c) || stl_pkg::is_digit(c));
				rec_a  = mk_rec(stl_pkg::ident_kind(kw_q), tstart_q, len_q);
			end
			stl_pkg::MODE_NUMBER: begin
				emit_a = !stl_pkg::is_digit(c);
				rec_a  = mk_rec(stl_pkg::KIND_NUMBER, tstart_q, len_q);
			end
			stl_pkg::MODE_OPER_SLASH, stl_pkg::MODE_OPER: begin
				if (mode_q == stl_pkg::MODE_OPER_SLASH
						&& (c == stl_pkg::CH_SLASH || c == stl_pkg::CH_STAR)) begin
					// run before the comment opener, if any
					emit_a = len_q > OW'(1);
					rec_a  = mk_rec(stl_pkg::KIND_OPER, tstart_q, len_q - OW'(1));
				end else begin
					emit_a = !stl_pkg::is_op(c);
				end
			end
			default: emit_a = 1'b0;
		endcase

		// pending token flushed at end of input; an open string, char or block comment gives an error token
		if (eoi_s1) begin
			unique case (mode_m)
				stl_pkg::MODE_IDENT: begin
					emit_b = 1'b1;
					rec_b  = mk_rec(stl_pkg::ident_kind(kw_m), tstart_m, len_m);
				end
				stl_pkg::MODE_NUMBER: begin
					emit_b = 1'b1;
					rec_b  = mk_rec(stl_pkg::KIND_NUMBER, tstart_m, len_m);
				end
				stl_pkg::MODE_OPER, stl_pkg::MODE_OPER_SLASH: begin
					emit_b = 1'b1;
					rec_b  = mk_rec(stl_pkg::KIND_OPER, tstart_m, len_m);
				end
				stl_pkg::MODE_STRING, stl_pkg::MODE_CHAR, stl_pkg::MODE_BLOCK: begin
					emit_b = 1'b1;
				end
				default: emit_b = 1'b0;
			endcase
		end

		rec_a.last_of_item = !emit_b;
		rec_a.final_token  = eoi_s1 && !emit_b;
		rec_b.last_of_item = 1'b1;
		rec_b.final_token  = 1'b1;
	end

	assign first_rec = emit_a ? rec_a : rec_b;
	assign push_cnt = {1'b0, emit_a} + {1'b0, emit_b};

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= stl_pkg::MODE_IDLE;
			kw_q     <= stl_pkg::KW_NONE;
			pos_q    <= '0;
			tstart_q <= '0;
			len_q    <= '0;
			pstar_q  <= 1'b0;
		end else if (adv) begin
			if (eoi_s1) begin
				mode_q   <= stl_pkg::MODE_IDLE;
				kw_q     <= stl_pkg::KW_NONE;
				pos_q    <= '0;
				tstart_q <= '0;
				len_q    <= '0;
				pstar_q  <= 1'b0;
			end else begin
				mode_q   <= mode_m;
				kw_q     <= kw_m;
				pos_q    <= sat_inc(pos_q);
				tstart_q <= tstart_m;
				len_q    <= len_m;
				pstar_q  <= pstar_m;
			end
		end
	end

	// buffer pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (adv) wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt & {2{adv}});
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(adv ? push_cnt : 2'd0) - CNT_W'(pop);
		end
	end

	// buffer storage
	always_ff @(posedge clk) begin
		if (adv && (emit_a || emit_b)) fifo_q[wr_ptr_q] <= first_rec;
		if (adv && emit_a && emit_b) fifo_q[wr_ptr_q + PTR_W'(1)] <= rec_b;
	end

	// output beat
	assign tokens.valid        = cnt_q != '0;
	assign tokens.token_kind   = fifo_q[rd_ptr_q].token_kind;
	assign tokens.start_offset = fifo_q[rd_ptr_q].start_offset;
	assign tokens.token_length = fifo_q[rd_ptr_q].token_length;
	assign tokens.last_of_item = fifo_q[rd_ptr_q].last_of_item;
	assign tokens.final_token  = fifo_q[rd_ptr_q].final_token;

`ifndef SYNTHESIS
	// buffer never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("token buffer count beyond depth");

	// the final token of a source is also the last of its byte
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.final_token |-> tokens.last_of_item)
		else $error("final token without last_of_item");

	// end of input returns the lexer to its reset state
	a_eoi_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eoi_s1 |=> pos_q == '0 && mode_q == stl_pkg::MODE_IDLE && len_q == '0)
		else $error("lexer state not cleared after end of input");
`endif

endmodule
